### hdl/integer_to_ascii_formatter_top_assert.svh
// Assertion macros shared by the formatter RTL.
`ifndef INTEGER_TO_ASCII_FORMATTER_TOP_ASSERT_SVH
`define INTEGER_TO_ASCII_FORMATTER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ITOA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ITOA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/itoa_pkg.sv
// Shared types, codes and character helpers for the integer formatter.
`default_nettype none

package itoa_pkg;

  localparam int VALUE_WIDTH_DEF = 64;
  localparam int COUNT_WIDTH_DEF = 32;

  // Mode codes on the op field
  localparam logic [2:0] OP_SDEC = 3'd0;
  localparam logic [2:0] OP_UDEC = 3'd1;
  localparam logic [2:0] OP_HEXL = 3'd2;
  localparam logic [2:0] OP_HEXU = 3'd3;
  localparam logic [2:0] OP_PTR  = 3'd4;

  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_LA    = 8'h61;  // 'a'
  localparam logic [7:0] CH_UA    = 8'h41;  // 'A'
  localparam logic [7:0] CH_MINUS = 8'h2d;  // '-'
  localparam logic [7:0] CH_X     = 8'h78;  // 'x'

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_EMIT
  } itoa_state_t;

  // Commands from the sequencer to the digit shifter
  typedef struct packed {
    logic load;    // take a new magnitude
    logic hex;     // with load: nibbles go straight in
    logic dabble;  // one shift-and-add-3 step
    logic shift;   // drop the top digit
  } itoa_dig_ctl_t;

  function automatic logic [7:0] dig_char(input logic [3:0] d, input logic upper);
    logic [7:0] res;
    if (d < 4'd10) begin
      res = CH_ZERO + {4'd0, d};
    end else begin
      res = (upper ? CH_UA : CH_LA) + {4'd0, d - 4'd10};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### hdl/itoa_digits.sv
// Digit shift register: bit-serial binary to BCD and nibble-wise digit shifting.
`default_nettype none

module itoa_digits #(
  parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEF,
  parameter int NUM_DIGITS  = 20
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire itoa_pkg::itoa_dig_ctl_t ctl,
  input  wire logic [VALUE_WIDTH-1:0]  mag,
  output logic [3:0]                   top_dig
);

  localparam int HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
  localparam int DW         = NUM_DIGITS * 4;

  logic [DW-1:0]          dig_r, dig_nxt;
  logic [VALUE_WIDTH-1:0] mag_r, mag_nxt;
  logic [DW-1:0]          adj;
  logic [HEX_DIGITS*4-1:0] hex_w;

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      adj[i*4 +: 4] = (dig_r[i*4 +: 4] >= 4'd5) ? dig_r[i*4 +: 4] + 4'd3 : dig_r[i*4 +: 4];
    end
  end

  assign hex_w = (HEX_DIGITS*4)'(mag);

  always_comb begin
    dig_nxt = dig_r;
    mag_nxt = mag_r;
    if (ctl.load) begin
      if (ctl.hex) begin
        // left-align the nibbles so the top digit is the most significant one
        dig_nxt = DW'(hex_w) << ((NUM_DIGITS - HEX_DIGITS) * 4);
      end else begin
        dig_nxt = '0;
        mag_nxt = mag;
      end
    end else if (ctl.dabble) begin
      dig_nxt = {adj[DW-2:0], mag_r[VALUE_WIDTH-1]};
      mag_nxt = mag_r << 1;
    end else if (ctl.shift) begin
      dig_nxt = dig_r << 4;
    end
  end

  always_ff @(posedge clk) begin
    dig_r <= dig_nxt;
    mag_r <= mag_nxt;
  end

  assign top_dig = dig_r[DW-1 -: 4];

  // rst_n only gates the checks below
  `include "integer_to_ascii_formatter_top_assert.svh"

  `ITOA_ASSERT_NOW(a_one_cmd, ctl.load || ctl.dabble || ctl.shift, $onehot({ctl.load, ctl.dabble, ctl.shift}), "digit shifter got more than one command")
  `ITOA_ASSERT_NEXT(a_load_dec_clear, ctl.load && !ctl.hex, dig_r == '0, "decimal load did not clear digits")
  `ITOA_ASSERT_NEXT(a_dabble_bcd, ctl.dabble, top_dig <= 4'd9, "BCD digit out of range")

endmodule

`default_nettype wire

### hdl/integer_to_ascii_formatter_top.sv
// Top level of the integer to ASCII formatter: sequencer, prefix logic and output register.
//
//   channel | direction | handshake            | beat payload
//   --------+-----------+----------------------+----------------------------------------
//   in_     | input     | in_valid / in_stall  | in_op[2:0], in_value[63:0]
//   out_    | output    | out_valid / out_stall| out_char_out[7:0], out_last,
//           |           |                      | out_total_chars[31:0]
//
// Sequence: one item is worked at a time. Decimal modes load the value, run VALUE_WIDTH
//   shift-and-add-3 steps in the digit shifter, drop leading zeros, then send the characters
//   one by one, a minus sign first when negative. Hex modes load the nibbles directly and
//   go straight to dropping leading zeros; pointer mode does the same and sends "0x" first.
//   While out_stall is high, the sending of characters is held.
// Reset: rst_n is synchronous, active low; it clears the sequencer, the output valid
//   and the character count. Digit and payload registers are not reset.
// Stalls: out_stall holds the output register; the sequencer waits with it. in_stall
//   is high from acceptance until the last character has been loaded into the output
//   register, so the next beat can enter while that character still waits.
// Undefined op codes are accepted and dropped without output.
`default_nettype none

module integer_to_ascii_formatter_top #(
  parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEF,
  parameter int COUNT_WIDTH = itoa_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_op,
  input  wire logic [63:0] in_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_char_out,
  output logic             out_last,
  output logic [31:0]      out_total_chars
);

  // decimal digits of 2^VALUE_WIDTH - 1: floor(W*log10(2)) + 1
  localparam int NUM_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
  localparam int RW         = $clog2(NUM_DIGITS + 1);
  localparam int BW         = $clog2(VALUE_WIDTH);

  itoa_pkg::itoa_state_t   state_r, state_nxt;
  logic [BW-1:0]           bit_cnt_r, bit_cnt_nxt;
  logic [RW-1:0]           rem_r, rem_nxt;      // digits still in the shifter
  logic [1:0]              pfx_r, pfx_nxt;      // prefix characters still to send
  logic                    ptr_r, ptr_nxt;      // prefix is "0x", else "-"
  logic                    upper_r, upper_nxt;
  logic [COUNT_WIDTH-1:0]  cnt_r, cnt_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [7:0]              out_char_r, out_char_nxt;
  logic                    out_last_r, out_last_nxt;
  logic [31:0]             out_total_r, out_total_nxt;

  itoa_pkg::itoa_dig_ctl_t dig_ctl;
  logic [VALUE_WIDTH-1:0]  val_in, mag_in;
  logic                    neg_in;
  logic [3:0]              top_dig;
  logic                    slot_free;
  logic                    load_char;
  logic [63:0]             cnt_ext;

  assign val_in    = in_value[VALUE_WIDTH-1:0];
  assign neg_in    = val_in[VALUE_WIDTH-1];
  // true magnitude; the most negative value comes out as 2^(W-1) unsigned
  assign mag_in    = (in_op == itoa_pkg::OP_SDEC && neg_in) ?
                     VALUE_WIDTH'(~val_in + VALUE_WIDTH'(1)) : val_in;
  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != itoa_pkg::ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    bit_cnt_nxt   = bit_cnt_r;
    rem_nxt       = rem_r;
    pfx_nxt       = pfx_r;
    ptr_nxt       = ptr_r;
    upper_nxt     = upper_r;
    dig_ctl       = '0;
    load_char     = 1'b0;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      itoa_pkg::ST_IDLE: begin
        if (in_valid) begin
          bit_cnt_nxt = '0;
          upper_nxt   = 1'b0;
          ptr_nxt     = 1'b0;
          pfx_nxt     = 2'd0;
          case (in_op)
            itoa_pkg::OP_SDEC: begin
              dig_ctl.load = 1'b1;
              pfx_nxt      = neg_in ? 2'd1 : 2'd0;
              rem_nxt      = RW'(NUM_DIGITS);
              state_nxt    = itoa_pkg::ST_CONV;
            end
            itoa_pkg::OP_UDEC: begin
              dig_ctl.load = 1'b1;
              rem_nxt      = RW'(NUM_DIGITS);
              state_nxt    = itoa_pkg::ST_CONV;
            end
            itoa_pkg::OP_HEXL, itoa_pkg::OP_HEXU: begin
              dig_ctl.load = 1'b1;
              dig_ctl.hex  = 1'b1;
              upper_nxt    = (in_op == itoa_pkg::OP_HEXU);
              rem_nxt      = RW'(HEX_DIGITS);
              state_nxt    = itoa_pkg::ST_SKIP;
            end
            itoa_pkg::OP_PTR: begin
              dig_ctl.load = 1'b1;
              dig_ctl.hex  = 1'b1;
              ptr_nxt      = 1'b1;
              pfx_nxt      = 2'd2;
              rem_nxt      = RW'(HEX_DIGITS);
              state_nxt    = itoa_pkg::ST_SKIP;
            end
            default: begin
              // drop the beat: no characters, count unchanged
            end
          endcase
        end
      end

      itoa_pkg::ST_CONV: begin
        dig_ctl.dabble = 1'b1;
        bit_cnt_nxt    = bit_cnt_r + 1'b1;
        if (bit_cnt_r == BW'(VALUE_WIDTH - 1)) begin
          state_nxt = itoa_pkg::ST_SKIP;
        end
      end

      itoa_pkg::ST_SKIP: begin
        // drop leading zeros, keep at least one digit
        if (top_dig == 4'd0 && rem_r > RW'(1)) begin
          dig_ctl.shift = 1'b1;
          rem_nxt       = rem_r - 1'b1;
        end else begin
          state_nxt = itoa_pkg::ST_EMIT;
        end
      end

      itoa_pkg::ST_EMIT: begin
        if (slot_free) begin
          load_char = 1'b1;
          if (pfx_r != 2'd0) begin
            pfx_nxt      = pfx_r - 1'b1;
            out_last_nxt = 1'b0;
            if (pfx_r == 2'd2) begin
              out_char_nxt = itoa_pkg::CH_ZERO;
            end else begin
              out_char_nxt = ptr_r ? itoa_pkg::CH_X : itoa_pkg::CH_MINUS;
            end
          end else begin
            out_char_nxt  = itoa_pkg::dig_char(top_dig, upper_r);
            out_last_nxt  = (rem_r == RW'(1));
            dig_ctl.shift = 1'b1;
            rem_nxt       = rem_r - 1'b1;
            if (rem_r == RW'(1)) begin
              state_nxt = itoa_pkg::ST_IDLE;
            end
          end
        end
      end

      default: begin
        state_nxt = itoa_pkg::ST_IDLE;
      end
    endcase
  end

  // Character count and output register
  assign cnt_nxt = load_char ? cnt_r + 1'b1 : cnt_r;
  assign cnt_ext = 64'(cnt_nxt);

  always_comb begin
    out_total_nxt = out_total_r;
    if (load_char) begin
      out_total_nxt = cnt_ext[31:0];
    end
    if (load_char) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= itoa_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bit_cnt_r   <= bit_cnt_nxt;
    rem_r       <= rem_nxt;
    pfx_r       <= pfx_nxt;
    ptr_r       <= ptr_nxt;
    upper_r     <= upper_nxt;
    out_char_r  <= out_char_nxt;
    out_last_r  <= out_last_nxt;
    out_total_r <= out_total_nxt;
  end

  itoa_digits #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .NUM_DIGITS  (NUM_DIGITS)
  ) u_digits (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (dig_ctl),
    .mag     (mag_in),
    .top_dig (top_dig)
  );

  assign out_valid       = out_valid_r;
  assign out_char_out    = out_char_r;
  assign out_last        = out_last_r;
  assign out_total_chars = out_total_r;

  `include "integer_to_ascii_formatter_top_assert.svh"

  `ITOA_ASSERT_NEXT(a_count_step, load_char, cnt_r == COUNT_WIDTH'($past(cnt_r) + 1'b1), "character count did not advance by one")
  `ITOA_ASSERT_NOW(a_rem_live, state_r == itoa_pkg::ST_SKIP || state_r == itoa_pkg::ST_EMIT, rem_r != '0, "no digit left while emitting")
  `ITOA_ASSERT_NOW(a_last_idle, load_char && out_last_nxt, state_nxt == itoa_pkg::ST_IDLE, "last character without return to idle")
  `ITOA_ASSERT_NOW(a_pfx_first, state_r == itoa_pkg::ST_CONV || state_r == itoa_pkg::ST_SKIP, pfx_r != 2'd3, "bad prefix count")

endmodule

`default_nettype wire
